// File: rtl/core/khash_pkg.sv
// Shared constants and a helper for the k-gram djb2 window hasher.
// No dependencies; imported by khash_cell and kgram_djb2_window_hasher.
`default_nettype none

package khash_pkg;

    // Longest window the accumulator row supports
    localparam int MAX_WINDOW = 16;

    // Field widths fixed by the stream format
    localparam int TOKEN_W = 64;
    localparam int CFG_W   = 5;

    // Held-token count covers 0..MAX_WINDOW, accumulator index covers 0..MAX_WINDOW-1
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // djb2 starting value
    localparam logic [TOKEN_W-1:0] HASH_SEED = TOKEN_W'(5381);

    // Map the window register to a usable length: zero means one, clamp at MAX_WINDOW
    function automatic logic [CNT_W-1:0] effective_window(input logic [CFG_W-1:0] cfg);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(cfg);
        if (wide == '0) begin
            wide = CMP_W'(1);
        end else if (wide > CMP_W'(MAX_WINDOW)) begin
            wide = CMP_W'(MAX_WINDOW);
        end
        return CNT_W'(wide);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/khash_cell.sv
// One accumulator cell of the window hash row: hash = prev*33 + token.
// Depends on khash_pkg.
`default_nettype none

module khash_cell (
    input  wire logic                            aclk,
    input  wire logic                            shift_en,
    input  wire logic [khash_pkg::TOKEN_W-1:0]   acc_in,
    input  wire logic [khash_pkg::TOKEN_W-1:0]   token,
    output logic      [khash_pkg::TOKEN_W-1:0]   acc_next,
    output logic      [khash_pkg::TOKEN_W-1:0]   acc_reg
);
    import khash_pkg::*;

    // Extend the neighbor's shorter-window hash by one token
    assign acc_next = (acc_in << 5) + acc_in + token;

    // Advance on every accepted token
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/kgram_djb2_window_hasher.sv
// Top level of the k-gram djb2 window hasher: cell row, count and output register.
// Depends on khash_pkg and khash_cell.
`default_nettype none

// Takes one 64-bit token per cycle while s_tready is high and, once window_length
// tokens have arrived since the last restart, returns the djb2 hash of the last
// window_length tokens in the cycle after the token's transfer. A row of MAX_WINDOW
// accumulator cells holds the hash of the last 1, 2, ... MAX_WINDOW tokens; each
// accepted token moves every cell one step (shift-add of the neighbor's value plus
// the token), so the row sustains one token per clock unless a result waits
// untaken, and the output register decouples the result side. A window_length of
// zero acts as one, above MAX_WINDOW as MAX_WINDOW; a change between streams keeps
// the history. A token with the restart flag starts a new stream before it is taken.
module kgram_djb2_window_hasher (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration: window_length
    input  wire logic                            cfg_wr_en,
    input  wire logic [khash_pkg::CFG_W-1:0]     cfg_wr_data,
    // Input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [khash_pkg::TOKEN_W-1:0]   s_tdata,   // [63:0] token
    input  wire logic                            s_tuser,   // [0] restart
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [khash_pkg::TOKEN_W-1:0]   m_tdata    // [63:0] hash_value
);
    import khash_pkg::*;

    logic [CFG_W-1:0]   window_reg;
    logic [CNT_W-1:0]   held_reg;
    logic [CNT_W-1:0]   held_next;
    logic [CNT_W-1:0]   win_len;
    logic [IDX_W-1:0]   win_idx;
    logic               s_xfer;
    logic               emit;
    logic               out_valid_reg;
    logic [TOKEN_W-1:0] out_data_reg;

    logic [TOKEN_W-1:0] acc_in_row   [MAX_WINDOW];
    logic [TOKEN_W-1:0] acc_next_row [MAX_WINDOW];
    logic [TOKEN_W-1:0] acc_reg_row  [MAX_WINDOW];

    // Accept while the output register is empty or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= CFG_W'(5);
        end else if (cfg_wr_en) begin
            window_reg <= cfg_wr_data;
        end
    end

    assign win_len = effective_window(window_reg);
    assign win_idx = IDX_W'(win_len - CNT_W'(1));

    // Count tokens since restart, saturating at MAX_WINDOW
    always_comb begin
        if (s_tuser) begin
            held_next = CNT_W'(1);
        end else if (held_reg < CNT_W'(MAX_WINDOW)) begin
            held_next = held_reg + CNT_W'(1);
        end else begin
            held_next = held_reg;
        end
    end

    assign emit = (held_next >= win_len);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (s_xfer) begin
            held_reg <= held_next;
        end
    end

    // Accumulator row: cell i holds the hash of the last i+1 tokens
    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_row
            if (gi == 0) begin : g_head
                assign acc_in_row[gi] = HASH_SEED;
            end else begin : g_link
                assign acc_in_row[gi] = acc_reg_row[gi-1];
            end
            khash_cell u_acc (
                .aclk     (aclk),
                .shift_en (s_xfer),
                .acc_in   (acc_in_row[gi]),
                .token    (s_tdata),
                .acc_next (acc_next_row[gi]),
                .acc_reg  (acc_reg_row[gi])
            );
        end
    endgenerate

    // Output register: load on an emitting transfer, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_xfer && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && emit) begin
            out_data_reg <= acc_next_row[win_idx];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Count never exceeds the row length
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNT_W'(MAX_WINDOW))
        else $error("held count above MAX_WINDOW");

    // Restart token leaves exactly one token held
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_tuser |=> held_reg == CNT_W'(1))
        else $error("restart did not reset held count");

    // Non-restart transfer below saturation grows the count by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && !s_tuser && held_reg < CNT_W'(MAX_WINDOW)
        |=> held_reg == $past(held_reg) + CNT_W'(1))
        else $error("held count did not advance");

    // Full window on transfer must produce a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && held_next >= win_len |=> m_tvalid)
        else $error("missing result for full window");

    // Short window on transfer must not produce a new result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && held_next < win_len && !m_tvalid |=> !m_tvalid)
        else $error("result emitted for short window");

endmodule

`default_nettype wire

// File: sim/kgram_djb2_window_hasher_tb.sv
// Self-checking testbench for kgram_djb2_window_hasher: drives token transfers with random
// gaps and stalls, predicts every window hash and compares each result transfer with it.
// Depends on khash_pkg and the hasher RTL.

module kgram_djb2_window_hasher_tb;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 12;
    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES       = 16;
    localparam int PHASE_TOKENS = 100;
    localparam int DEPTH        = khash_pkg::MAX_WINDOW;
    localparam logic [khash_pkg::TOKEN_W-1:0] DJB2_START = 64'd5381;
    // Window settings swept first: extremes, zero, above the row length
    localparam logic [khash_pkg::CFG_W-1:0] WINDOW_SWEEP [8] =
        '{5'd1, 5'd16, 5'd0, 5'd17, 5'd31, 5'd2, 5'd15, 5'd8};

    // Track token history and queue the hash each token should produce
    class window_hash_tracker;
        logic [khash_pkg::TOKEN_W-1:0] recent [DEPTH];
        int unsigned                   held;
        logic [khash_pkg::CFG_W-1:0]   window_reg;
        logic [khash_pkg::TOKEN_W-1:0] expected_hashes [$];
        int unsigned                   mismatches;

        function new();
            foreach (recent[i]) recent[i] = '0;
            held       = 0;
            window_reg = 5'd5;
            mismatches = 0;
        endfunction

        function void set_window(logic [khash_pkg::CFG_W-1:0] value);
            window_reg = value;
        endfunction

        // Shift the token in and queue the hash of the window ending with it
        function void take_token(logic [khash_pkg::TOKEN_W-1:0] tok, logic restart);
            int unsigned                   k;
            logic [khash_pkg::TOKEN_W-1:0] h;
            k = (window_reg == 0) ? 1 : ((window_reg > DEPTH) ? DEPTH : window_reg);
            if (restart) held = 0;
            for (int i = DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
            recent[0] = tok;
            if (held < DEPTH) held++;
            if (held >= k) begin
                h = DJB2_START;
                // oldest token of the window first
                for (int i = int'(k) - 1; i >= 0; i--) h = (h << 5) + h + recent[i];
                expected_hashes.push_back(h);
            end
        endfunction

        function void compare_hash(logic [khash_pkg::TOKEN_W-1:0] got);
            logic [khash_pkg::TOKEN_W-1:0] want;
            if (expected_hashes.size() == 0) begin
                mismatches++;
                $display("%0t: hash_value expected none, actual %h", $time, got);
            end else begin
                want = expected_hashes.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: hash_value expected %h, actual %h", $time, want, got);
                end
            end
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [khash_pkg::CFG_W-1:0]     cfg_wr_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [khash_pkg::TOKEN_W-1:0]   s_tdata;   // [63:0] token
    logic                            s_tuser;   // [0] restart
    logic                            m_tvalid;
    logic                            m_tready;
    logic [khash_pkg::TOKEN_W-1:0]   m_tdata;   // [63:0] hash_value

    window_hash_tracker tracker;
    bit                 idling_on = 1'b1;
    int                 quiet_cycles = 0;

    kgram_djb2_window_hasher i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // Observe transfers and register writes; a result is never taken in the same cycle as its token
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) tracker.compare_hash(m_tdata);
            if (s_tvalid && s_tready) tracker.take_token(s_tdata, s_tuser);
            if (cfg_wr_en) tracker.set_window(cfg_wr_data);
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: stall a random number of cycles before each transfer
    initial begin : hash_sink
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = idling_on ? $urandom_range(0, 3) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Offer one token after a random gap and hold it until the transfer
    task automatic send_token(input logic [khash_pkg::TOKEN_W-1:0] tok, input logic restart);
        int gap;
        gap = idling_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tok;
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold the sender until every queued hash has been transferred, then let the block settle
    task automatic wait_for_hashes();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.expected_hashes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [khash_pkg::CFG_W-1:0] value);
        wait_for_hashes();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : token_source
        logic [khash_pkg::TOKEN_W-1:0] tok;
        logic [khash_pkg::CFG_W-1:0]   win;
        tracker     = new();
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset window of five: four tokens give nothing, then one hash per token
        send_token('0, 1'b0);
        send_token('1, 1'b0);
        send_token(64'h8000_0000_0000_0000, 1'b0);
        send_token(64'd1, 1'b0);
        send_token('1, 1'b0);
        send_token('0, 1'b0);
        // Restart drops the history; the window refills from the restart token
        send_token('1, 1'b1);
        send_token(64'h5555_5555_5555_5555, 1'b0);
        send_token(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_token('0, 1'b0);
        send_token('1, 1'b0);
        // Zero window acts as one
        write_window(5'd0);
        send_token('1, 1'b1);
        send_token(64'h0123_4567_89AB_CDEF, 1'b0);
        // Longest window on the kept history, then settings above the row length
        write_window(5'd16);
        repeat (4) send_token('1, 1'b0);
        write_window(5'd31);
        repeat (4) send_token('0, 1'b0);
        write_window(5'd17);
        send_token(64'hFEDC_BA98_7654_3210, 1'b1);
        send_token('1, 1'b0);

        // Random phases; every fourth phase runs with no gaps or stalls
        for (int p = 0; p < PHASES; p++) begin
            win = (p < 8) ? WINDOW_SWEEP[p] : khash_pkg::CFG_W'($urandom_range(0, 31));
            write_window(win);
            idling_on = (p % 4 != 3);
            for (int n = 0; n < PHASE_TOKENS; n++) begin
                if (n == PHASE_TOKENS / 2) wait_for_hashes();
                case ($urandom_range(0, 9))
                    0:       tok = '0;
                    1:       tok = '1;
                    default: tok = {$urandom, $urandom};
                endcase
                send_token(tok, ($urandom_range(0, 39) == 0) || (n == 0 && p % 2 == 1));
            end
        end

        wait_for_hashes();
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.expected_hashes.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
